FILE: hdl/wbps_pkg.sv
// shared types and constants for the wildcard byte pattern search
package wbps_pkg;

   // defaults for the top-level parameters
   localparam int PATTERN_MAX_DEFAULT  = 16;
   localparam int OFFSET_WIDTH_DEFAULT = 32;

   // fixed field widths
   localparam int ADDR_WIDTH      = 64;
   localparam int TALLY_WIDTH     = 32;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int MASK_WIDTH      = 16;
   localparam int LENGTH_WIDTH    = 5;

   // response queue
   localparam int RSP_QUEUE_DEPTH = 4;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BASE_ADDRESS       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_BYTES_LOW  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_BYTES_HIGH = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WILDCARD_MASK      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LENGTH     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_MATCH_ONLY   = 3'd5;

   // result kinds
   localparam logic KIND_MATCH   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [TALLY_WIDTH-1:0] TALLY_MAX = '1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       region_end;
   } req_word_type;

   typedef struct packed {
      logic                   result_kind;
      logic [ADDR_WIDTH-1:0]  match_address;
      logic [TALLY_WIDTH-1:0] match_total;
      logic                   last;
   } rsp_word_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0]   base_address;
      logic [63:0]             pattern_bytes_low;
      logic [63:0]             pattern_bytes_high;
      logic [MASK_WIDTH-1:0]   wildcard_mask;
      logic [LENGTH_WIDTH-1:0] pattern_length;
      logic                    first_match_only;
   } cfg_type;

   // up to two result words produced by one byte, first slot filled first
   typedef struct packed {
      logic         first_valid;
      logic         second_valid;
      rsp_word_type first_word;
      rsp_word_type second_word;
   } push_type;

endpackage

FILE: hdl/wbps_scan.sv
// byte window, masked pattern compare and per-region counters
module wbps_scan #(
   parameter int PATTERN_MAX  = wbps_pkg::PATTERN_MAX_DEFAULT,
   parameter int OFFSET_WIDTH = wbps_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  wbps_pkg::req_word_type word,
   input  wbps_pkg::cfg_type     cfg,
   output wbps_pkg::push_type    push
);

   localparam int WIN_DEPTH  = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
   localparam int LEN_WIDTH  = $clog2(PATTERN_MAX + 1);
   localparam int AGE_WIDTH  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   logic [7:0]                       window_ff [WIN_DEPTH];
   logic [7:0]                       window_in [WIN_DEPTH];
   logic [OFFSET_WIDTH-1:0]          offset_ff, offset_in;
   logic [LEN_WIDTH-1:0]             fill_ff, fill_in;
   logic [wbps_pkg::TALLY_WIDTH-1:0] tally_ff, tally_in;
   logic                             seen_ff, seen_in;

   logic [7:0]                       aged [PATTERN_MAX];
   logic [LEN_WIDTH-1:0]             len_eff;
   logic [LEN_WIDTH-1:0]             fill_bump;
   logic [PATTERN_MAX-1:0]           pos_ok;
   logic [127:0]                     pattern_all;
   logic                             hit;
   logic [wbps_pkg::TALLY_WIDTH-1:0] tally_bump;
   logic [OFFSET_WIDTH-1:0]          start;
   wbps_pkg::rsp_word_type           match_word, summary_word;

   // newest byte at age 0
   always_comb begin
      aged[0] = word.data_byte;
      for (int a = 1; a < PATTERN_MAX; a++) begin
         aged[a] = window_ff[a-1];
      end
   end

   // lengths above the supported maximum act as the maximum
   always_comb begin
      if (cfg.pattern_length > wbps_pkg::LENGTH_WIDTH'(PATTERN_MAX)) begin
         len_eff = LEN_WIDTH'(PATTERN_MAX);
      end else begin
         len_eff = LEN_WIDTH'(cfg.pattern_length);
      end
   end

   assign pattern_all = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};

   // pattern byte k lines up with the byte of age len-1-k
   always_comb begin
      logic                 active;
      logic [LEN_WIDTH-1:0] age_full;
      logic [AGE_WIDTH-1:0] age;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         active   = LEN_WIDTH'(k) < len_eff;
         age_full = len_eff - LEN_WIDTH'(k + 1);
         age      = age_full[AGE_WIDTH-1:0];
         pos_ok[k] = !active || cfg.wildcard_mask[k] ||
                     (aged[age] == pattern_all[8*k +: 8]);
      end
   end

   assign fill_bump = (fill_ff < LEN_WIDTH'(PATTERN_MAX)) ? fill_ff + 1'b1 : fill_ff;

   assign hit = (len_eff != '0) && (fill_bump >= len_eff) &&
                !(cfg.first_match_only && seen_ff) && (&pos_ok);

   assign tally_bump = (hit && tally_ff != wbps_pkg::TALLY_MAX) ? tally_ff + 1'b1 : tally_ff;

   assign start = offset_ff - OFFSET_WIDTH'(len_eff) + OFFSET_WIDTH'(1);

   always_comb begin
      match_word.result_kind   = wbps_pkg::KIND_MATCH;
      match_word.match_address = cfg.base_address + wbps_pkg::ADDR_WIDTH'(start);
      match_word.match_total   = tally_bump;
      match_word.last          = !word.region_end;

      summary_word.result_kind   = wbps_pkg::KIND_SUMMARY;
      summary_word.match_address = '0;
      summary_word.match_total   = tally_bump;
      summary_word.last          = 1'b1;
   end

   always_comb begin
      push.first_valid  = enable && (hit || word.region_end);
      push.second_valid = enable && hit && word.region_end;
      push.first_word   = hit ? match_word : summary_word;
      push.second_word  = summary_word;
   end

   // region state: shift and count, or clear after the final byte
   always_comb begin
      window_in = window_ff;
      offset_in = offset_ff;
      fill_in   = fill_ff;
      tally_in  = tally_ff;
      seen_in   = seen_ff;
      if (enable) begin
         if (word.region_end) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
               window_in[i] = '0;
            end
            offset_in = '0;
            fill_in   = '0;
            tally_in  = '0;
            seen_in   = 1'b0;
         end else begin
            window_in[0] = word.data_byte;
            for (int i = 1; i < WIN_DEPTH; i++) begin
               window_in[i] = window_ff[i-1];
            end
            offset_in = offset_ff + 1'b1;
            fill_in   = fill_bump;
            tally_in  = tally_bump;
            seen_in   = seen_ff || hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
         offset_ff <= '0;
         fill_ff   <= '0;
         tally_ff  <= '0;
         seen_ff   <= 1'b0;
      end else begin
         window_ff <= window_in;
         offset_ff <= offset_in;
         fill_ff   <= fill_in;
         tally_ff  <= tally_in;
         seen_ff   <= seen_in;
      end
   end

endmodule

FILE: hdl/wbps_rsp_queue.sv
// small response queue taking up to two words per cycle
module wbps_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  wbps_pkg::push_type     push,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wbps_pkg::rsp_word_type rsp_word
);

   localparam int DEPTH       = wbps_pkg::RSP_QUEUE_DEPTH;
   localparam int PTR_WIDTH   = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   wbps_pkg::rsp_word_type mem [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   pop;
   logic [1:0]             push_count;

   assign rsp_valid  = count_ff != '0;
   assign rsp_word   = mem[rd_ptr_ff];
   assign room       = count_ff <= COUNT_WIDTH'(DEPTH - 2);
   assign pop        = rsp_valid && !rsp_stall;
   assign push_count = {1'b0, push.first_valid} + {1'b0, push.second_valid};

   assign wr_ptr_in = wr_ptr_ff + PTR_WIDTH'(push_count);
   assign rd_ptr_in = rd_ptr_ff + PTR_WIDTH'(pop);
   assign count_in  = count_ff + COUNT_WIDTH'(push_count) - COUNT_WIDTH'(pop);

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem[wr_ptr_ff] <= push.first_word;
      end
      if (push.second_valid) begin
         mem[PTR_WIDTH'(wr_ptr_ff + 1'b1)] <= push.second_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hdl/wildcard_byte_pattern_search.sv
// top level of the wildcard byte pattern search
//
// Scans a region one byte per word and reports every place where the newest
// pattern_length bytes equal the configured pattern, wildcard positions
// matching anything (with first_match_only set, only the first such place
// in the region). A match word carries base_address plus the offset of the
// window start; the final byte of a region (region_end) always produces a
// summary word with the saturated match count, after which the window,
// offset and counts clear while the registers keep their values. The block
// takes one byte per cycle while req_stall is low: each byte is held in an
// input register, then compared and counted, and its words land in a
// four-entry response queue. The only byte that yields two words is a final
// byte that also matches, and req_stall rises only when the response queue
// has fewer than two free entries. Registers are written through the csr_
// port and should change only between regions.
module wildcard_byte_pattern_search #(
   parameter int PATTERN_MAX  = wbps_pkg::PATTERN_MAX_DEFAULT,
   parameter int OFFSET_WIDTH = wbps_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,

   // byte stream
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  wbps_pkg::req_word_type                 req_word,

   // results
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output wbps_pkg::rsp_word_type                 rsp_word,

   // register writes
   input  logic                                   csr_write_enable,
   input  logic [wbps_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [wbps_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   wbps_pkg::cfg_type      cfg_ff, cfg_in;
   logic                   in_valid_ff, in_valid_in;
   wbps_pkg::req_word_type in_word_ff, in_word_in;
   logic                   room;
   logic                   advance;
   logic                   accept;
   wbps_pkg::push_type     push;

   // configuration registers, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            wbps_pkg::CSR_BASE_ADDRESS: begin
               cfg_in.base_address = csr_write_data;
            end
            wbps_pkg::CSR_PATTERN_BYTES_LOW: begin
               cfg_in.pattern_bytes_low = csr_write_data;
            end
            wbps_pkg::CSR_PATTERN_BYTES_HIGH: begin
               cfg_in.pattern_bytes_high = csr_write_data;
            end
            wbps_pkg::CSR_WILDCARD_MASK: begin
               cfg_in.wildcard_mask = csr_write_data[wbps_pkg::MASK_WIDTH-1:0];
            end
            wbps_pkg::CSR_PATTERN_LENGTH: begin
               cfg_in.pattern_length = csr_write_data[wbps_pkg::LENGTH_WIDTH-1:0];
            end
            wbps_pkg::CSR_FIRST_MATCH_ONLY: begin
               cfg_in.first_match_only = csr_write_data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // input register moves on whenever the queue can absorb two words
   assign advance     = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign in_word_in  = accept ? req_word : in_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '0;
         in_valid_ff <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
   end

   // payload holds no reset
   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
   end

   wbps_scan #(
      .PATTERN_MAX  (PATTERN_MAX),
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .word   (in_word_ff),
      .cfg    (cfg_ff),
      .push   (push)
   );

   wbps_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

FILE: sim/wbps_search_checker.sv
// checker for the wildcard byte pattern search: register mirror, match predictor, comparison
`timescale 1ns / 1ps
module wbps_search_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  wbps_pkg::req_word_type               req_word,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  wbps_pkg::rsp_word_type               rsp_word,
   input  logic                                 csr_write_enable,
   input  logic [wbps_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [wbps_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int                                   error_total,
   output int                                   pending_words
);

   localparam int PMAX = wbps_pkg::PATTERN_MAX_DEFAULT;
   localparam int OW   = wbps_pkg::OFFSET_WIDTH_DEFAULT;

   wbps_pkg::cfg_type                regs;
   logic [7:0]                       history [0:PMAX-2];   // slot 0 is the newest previous byte
   logic [OW-1:0]                    byte_pos;
   logic [wbps_pkg::TALLY_WIDTH-1:0] tally;
   logic                             got_match;
   int                               fill;
   wbps_pkg::rsp_word_type           expected_words [$];

   task automatic clear_region();
      for (int i = 0; i < PMAX - 1; i++) history[i] = 8'h00;
      byte_pos  = '0;
      tally     = '0;
      got_match = 1'b0;
      fill      = 0;
   endtask

   // append one predicted word at the tail of the expected queue
   task automatic add_expected(wbps_pkg::rsp_word_type r);
      expected_words = {expected_words, r};
   endtask

   // masked compare of the newest len bytes against pattern bytes 0..len-1
   function automatic logic window_hit(int len, logic [7:0] cur);
      logic [127:0] pat;
      logic [7:0]   d;
      int           age;
      pat = {regs.pattern_bytes_high, regs.pattern_bytes_low};
      for (int k = 0; k < len; k++) begin
         age = len - 1 - k;
         d = (age == 0) ? cur : history[age-1];
         if (!regs.wildcard_mask[k] && d != pat[8*k +: 8]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic predict_byte(wbps_pkg::req_word_type w);
      int                     len;
      wbps_pkg::rsp_word_type r;
      logic [OW-1:0]          start_pos;
      len = (regs.pattern_length > PMAX) ? PMAX : int'(regs.pattern_length);
      if (fill < PMAX) fill++;
      if (len != 0 && fill >= len && !(regs.first_match_only && got_match)
          && window_hit(len, w.data_byte)) begin
         start_pos = byte_pos - OW'(len - 1);
         if (tally != wbps_pkg::TALLY_MAX) tally++;
         got_match       = 1'b1;
         r.result_kind   = wbps_pkg::KIND_MATCH;
         r.match_address = regs.base_address + wbps_pkg::ADDR_WIDTH'(start_pos);
         r.match_total   = tally;
         r.last          = !w.region_end;
         add_expected(r);
      end
      if (w.region_end) begin
         r.result_kind   = wbps_pkg::KIND_SUMMARY;
         r.match_address = '0;
         r.match_total   = tally;
         r.last          = 1'b1;
         add_expected(r);
         clear_region();
      end else begin
         for (int i = PMAX - 2; i > 0; i--) history[i] = history[i-1];
         history[0] = w.data_byte;
         byte_pos   = byte_pos + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      wbps_pkg::rsp_word_type want;
      if (reset) begin
         regs = '0;
         clear_region();
         expected_words.delete();
         error_total = 0;
      end else begin
         if (req_valid === 1'b1 && req_stall === 1'b0) predict_byte(req_word);
         if (rsp_valid !== 1'b0 && rsp_stall === 1'b0) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word %p", rsp_word);
               error_total++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_word.result_kind !== want.result_kind) begin
                  $error("result_kind: expected %0d, got %0d",
                         want.result_kind, rsp_word.result_kind);
                  error_total++;
               end
               if (rsp_word.match_address !== want.match_address) begin
                  $error("match_address: expected %h, got %h",
                         want.match_address, rsp_word.match_address);
                  error_total++;
               end
               if (rsp_word.match_total !== want.match_total) begin
                  $error("match_total: expected %0d, got %0d",
                         want.match_total, rsp_word.match_total);
                  error_total++;
               end
               if (rsp_word.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_word.last);
                  error_total++;
               end
            end
         end
         // a write counts from the next byte on
         if (csr_write_enable === 1'b1) begin
            case (csr_index)
               wbps_pkg::CSR_BASE_ADDRESS: begin
                  regs.base_address = csr_write_data;
               end
               wbps_pkg::CSR_PATTERN_BYTES_LOW: begin
                  regs.pattern_bytes_low = csr_write_data;
               end
               wbps_pkg::CSR_PATTERN_BYTES_HIGH: begin
                  regs.pattern_bytes_high = csr_write_data;
               end
               wbps_pkg::CSR_WILDCARD_MASK: begin
                  regs.wildcard_mask = csr_write_data[wbps_pkg::MASK_WIDTH-1:0];
               end
               wbps_pkg::CSR_PATTERN_LENGTH: begin
                  regs.pattern_length = csr_write_data[wbps_pkg::LENGTH_WIDTH-1:0];
               end
               wbps_pkg::CSR_FIRST_MATCH_ONLY: begin
                  regs.first_match_only = csr_write_data[0];
               end
               default: ;
            endcase
         end
      end
      pending_words = expected_words.size();
   end

endmodule

FILE: sim/tb_top.sv
// top of the wildcard byte pattern search testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_top;

   localparam int PMAX         = wbps_pkg::PATTERN_MAX_DEFAULT;
   localparam int STUCK_LIMIT  = 4000;   // cycles with no word moving on either side
   localparam int DIRECTED     = 22;
   localparam int RANDOM_ITEMS = 1850;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   wbps_pkg::req_word_type               req_word;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   wbps_pkg::rsp_word_type               rsp_word;
   logic                                 csr_write_enable;
   logic [wbps_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [wbps_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data;

   int error_total;
   int pending_words;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_sent;
   int stuck_cycles = 0;

   // registers as last written; only used to plant pattern copies in the stream
   wbps_pkg::cfg_type shadow;

   wildcard_byte_pattern_search dut (.*);

   wbps_search_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: a fresh stall decision every cycle
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // watchdog: too long without any word accepted means the block hung
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
         $display("FAIL wildcard_byte_pattern_search");
         $finish;
      end
   end

   // offer one byte, maybe after a random gap, and hold it until it is taken;
   // returns at the following falling edge with valid still high, so the next
   // call either replaces the word or lowers valid, never both
   task automatic send_byte(logic [7:0] b, logic fin);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_word  <= '{data_byte: b, region_end: fin};
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      bytes_sent++;
   endtask

   // hold the sender until every predicted word has come out, then let the
   // pipeline finish bytes that produce nothing
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_words != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // back-to-back register writes for every register whose pick bit is set
   task automatic write_regs(wbps_pkg::cfg_type c, logic [5:0] pick);
      logic [wbps_pkg::CSR_INDEX_WIDTH-1:0] idx;
      logic [wbps_pkg::CSR_DATA_WIDTH-1:0]  v;
      for (int i = 0; i < 6; i++) begin
         if (pick[i]) begin
            idx = wbps_pkg::CSR_INDEX_WIDTH'(i);
            // narrow registers get junk in the unused upper bits
            v = {$urandom, $urandom};
            case (idx)
               wbps_pkg::CSR_BASE_ADDRESS: begin
                  v = c.base_address;
                  shadow.base_address = c.base_address;
               end
               wbps_pkg::CSR_PATTERN_BYTES_LOW: begin
                  v = c.pattern_bytes_low;
                  shadow.pattern_bytes_low = c.pattern_bytes_low;
               end
               wbps_pkg::CSR_PATTERN_BYTES_HIGH: begin
                  v = c.pattern_bytes_high;
                  shadow.pattern_bytes_high = c.pattern_bytes_high;
               end
               wbps_pkg::CSR_WILDCARD_MASK: begin
                  v[wbps_pkg::MASK_WIDTH-1:0] = c.wildcard_mask;
                  shadow.wildcard_mask = c.wildcard_mask;
               end
               wbps_pkg::CSR_PATTERN_LENGTH: begin
                  v[wbps_pkg::LENGTH_WIDTH-1:0] = c.pattern_length;
                  shadow.pattern_length = c.pattern_length;
               end
               default: begin
                  v[0] = c.first_match_only;
                  shadow.first_match_only = c.first_match_only;
               end
            endcase
            csr_write_enable <= 1'b1;
            csr_index        <= idx;
            csr_write_data   <= v;
            @(negedge clock);
         end
      end
      csr_write_enable <= 1'b0;
   endtask

   function automatic wbps_pkg::cfg_type random_settings();
      wbps_pkg::cfg_type c;
      case ($urandom_range(0, 3))
         0:       c.base_address = '0;
         1:       c.base_address = '1;
         2:       c.base_address = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 200);
         default: c.base_address = {$urandom, $urandom};
      endcase
      c.pattern_bytes_low  = {$urandom, $urandom};
      c.pattern_bytes_high = {$urandom, $urandom};
      // a tiny alphabet makes accidental matches in the noise likely
      if ($urandom_range(0, 2) == 0) begin
         for (int k = 0; k < 8; k++) begin
            c.pattern_bytes_low[8*k +: 8]  = 8'($urandom_range(0, 3));
            c.pattern_bytes_high[8*k +: 8] = 8'($urandom_range(0, 3));
         end
      end
      case ($urandom_range(0, 4))
         0:       c.wildcard_mask = '0;
         1:       c.wildcard_mask = '1;
         2:       c.wildcard_mask = 16'($urandom & $urandom & $urandom);
         default: c.wildcard_mask = 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0:       c.pattern_length = '0;
         1:       c.pattern_length = 5'(PMAX);
         2:       c.pattern_length = 5'($urandom_range(PMAX + 1, 31));   // clamps to max
         3, 4:    c.pattern_length = 5'($urandom_range(9, PMAX - 1));
         default: c.pattern_length = 5'($urandom_range(1, 8));
      endcase
      c.first_match_only = 1'($urandom_range(0, 1));
      return c;
   endfunction

   // one region of n bytes: planted pattern copies (some with a corrupted
   // byte) mixed with noise, partly drawn from the pattern's own bytes
   task automatic scan_region(int n);
      logic [7:0]   bytes [$];
      logic [127:0] pat;
      int           len;
      int           k;
      int           pick;
      pat = {shadow.pattern_bytes_high, shadow.pattern_bytes_low};
      len = (shadow.pattern_length > PMAX) ? PMAX : int'(shadow.pattern_length);
      while (bytes.size() < n) begin
         if (len != 0 && $urandom_range(0, 99) < 30) begin
            for (k = 0; k < len; k++)
               bytes = {bytes, (shadow.wildcard_mask[k] ? 8'($urandom) : pat[8*k +: 8])};
            if ($urandom_range(0, 9) == 0) begin
               k = bytes.size() - 1 - int'($urandom_range(0, len - 1));
               bytes[k] = bytes[k] ^ 8'($urandom_range(1, 255));
            end
         end else if (len != 0 && $urandom_range(0, 1) == 0) begin
            pick = $urandom_range(0, len - 1);
            bytes = {bytes, pat[8*pick +: 8]};
         end else begin
            bytes = {bytes, 8'($urandom)};
         end
      end
      for (k = 0; k < n; k++) begin
         // now and then let the result side run completely dry mid-region
         if ($urandom_range(0, 199) == 0) drain_results();
         send_byte(bytes[k], k == n - 1);
      end
   endtask

   initial begin
      wbps_pkg::cfg_type c;
      int                n;
      logic              first_pass;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_word         = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      bytes_sent       = 0;
      shadow           = '0;
      send_idle_pct    = 17;
      recv_idle_pct    = 88;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // 4-byte pattern 11 ?? 33 44, base just below the top of the address space
      c                   = '0;
      c.base_address      = 64'hFFFF_FFFF_FFFF_FFFE;
      c.pattern_bytes_low = 64'h4433_2211;
      c.wildcard_mask     = 16'h0002;
      c.pattern_length    = 5'd4;
      write_regs(c, 6'b111111);
      // wildcard hit at offset zero, then a hit on the final byte whose
      // address wraps past zero: match word first, summary after it
      send_byte(8'h11, 1'b0);
      send_byte(8'hAB, 1'b0);
      send_byte(8'h33, 1'b0);
      send_byte(8'h44, 1'b0);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);
      send_byte(8'h44, 1'b1);
      // region shorter than the pattern
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b1);

      // zero length never matches
      drain_results();
      c.pattern_length = '0;
      write_regs(c, 6'b010000);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);
      send_byte(8'h44, 1'b1);

      // first-only with a single all-wildcard byte: only the first byte reports a match
      drain_results();
      c                  = '0;
      c.wildcard_mask    = '1;
      c.pattern_length   = 5'd1;
      c.first_match_only = 1'b1;
      write_regs(c, 6'b111111);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);

      // pattern 00 FF; first-only switched on mid-region keeps the window
      drain_results();
      c                   = '0;
      c.pattern_bytes_low = 64'hFF00;
      c.pattern_length    = 5'd2;
      write_regs(c, 6'b111111);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      drain_results();
      c.first_match_only = 1'b1;
      write_regs(c, 6'b100000);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      // random regions in three idling phases: slow receiver, slow sender, none
      first_pass = 1'b1;
      while (bytes_sent < DIRECTED + RANDOM_ITEMS) begin
         if (bytes_sent < DIRECTED + RANDOM_ITEMS / 3) begin
            send_idle_pct = 17;
            recv_idle_pct = 88;
         end else if (bytes_sent < DIRECTED + 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 88;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // new settings only between regions, with the block idle
         if (first_pass || $urandom_range(0, 99) < 30) begin
            drain_results();
            write_regs(random_settings(), first_pass ? 6'b111111 : 6'($urandom_range(1, 63)));
            first_pass = 1'b0;
         end
         case ($urandom_range(0, 19))
            0:       n = $urandom_range(1, 3);
            1, 2:    n = $urandom_range(41, 120);
            default: n = $urandom_range(4, 40);
         endcase
         scan_region(n);
      end

      drain_results();
      repeat (8) @(negedge clock);
      if (error_total == 0 && pending_words == 0)
         $display("PASS wildcard_byte_pattern_search");
      else
         $display("FAIL wildcard_byte_pattern_search");
      $finish;
   end

endmodule
